### sv/mbnp_pkg.sv
// Shared types and encodings for the MIPS branch next-PC unit.
`timescale 1ns / 1ps
`default_nettype none
package mbnp_pkg;

    localparam int REG_WIDTH_DEF = 64;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DSP_PRESENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BBIT_ENABLE = CFG_IDX_W'(1);

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;
    localparam logic [5:0] OP_BBIT0   = 6'h32;
    localparam logic [5:0] OP_BBIT032 = 6'h36;
    localparam logic [5:0] OP_BBIT1   = 6'h3a;
    localparam logic [5:0] OP_BBIT132 = 6'h3e;

    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;

    localparam logic [4:0] COP1_BC = 5'h08;

    localparam logic [4:0] RT_BLTZ     = 5'h00;
    localparam logic [4:0] RT_BGEZ     = 5'h01;
    localparam logic [4:0] RT_BLTZL    = 5'h02;
    localparam logic [4:0] RT_BGEZL    = 5'h03;
    localparam logic [4:0] RT_BLTZAL   = 5'h10;
    localparam logic [4:0] RT_BGEZAL   = 5'h11;
    localparam logic [4:0] RT_BLTZALL  = 5'h12;
    localparam logic [4:0] RT_BGEZALL  = 5'h13;
    localparam logic [4:0] RT_BPOSGE32 = 5'h1c;

    localparam logic [4:0] LINK_RA   = 5'd31;
    localparam logic [4:0] FCC0_BIT  = 5'd23;
    localparam logic [4:0] FCC_BASE  = 5'd24;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISALIGN = 2'd1,
        ST_NO_DSP   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_PC     = 2'd0,
        SEL_REG    = 2'd1,
        SEL_JUMP   = 2'd2,
        SEL_BRANCH = 2'd3
    } t_sel;

    typedef struct packed {
        logic dsp_present;
        logic bbit_enable;
    } t_cfg;

    typedef struct packed {
        logic [63:0] pc;
        logic [63:0] pc4;
        logic [63:0] pc8;
        logic [63:0] off;
        logic [63:0] rs_w;
        logic [25:0] jidx;
        t_sel        sel;
        logic        taken;
        logic        likely;
        logic        link;
        logic [4:0]  lreg;
        t_status     status;
    } t_dec;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        link_write;
        logic [4:0]  link_reg;
        logic [63:0] link_value;
        logic        likely_taken;
        t_status     status;
    } t_res;

endpackage
`default_nettype wire

### sv/mbnp_if.sv
// Channel interfaces: instruction words in, resolved words out, config writes.
`timescale 1ns / 1ps
`default_nettype none
interface mbnp_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] instr;
    logic        [63:0] pc;
    logic signed [63:0] rs_value;
    logic signed [63:0] rt_value;
    logic        [31:0] fp_csr;
    logic        [5:0]  dsp_pos;

    modport source (output valid, instr, pc, rs_value, rt_value, fp_csr, dsp_pos,
                    input ready);
    modport sink   (input valid, instr, pc, rs_value, rt_value, fp_csr, dsp_pos,
                    output ready);
endinterface

interface mbnp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_pc;
    logic        link_write;
    logic [4:0]  link_reg;
    logic [63:0] link_value;
    logic        likely_taken;
    logic [1:0]  status;

    modport source (output valid, next_pc, link_write, link_reg, link_value,
                    likely_taken, status, input ready);
    modport sink   (input valid, next_pc, link_write, link_reg, link_value,
                    likely_taken, status, output ready);
endinterface

interface mbnp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mbnp_pkg::CFG_IDX_W-1:0]  index;
    logic [mbnp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/mips_branch_next_pc.sv
// Top level of the MIPS branch next-PC unit: config registers and output stage.
//
// Resolves one MIPS instruction word per cycle, unless o_out stalls, into its
// next PC, link write, branch-likely-taken flag and status.
// Channels: i_in carries the instruction word with its pc, rs/rt values, FP
// control/status and DSP pos; o_out returns one word per input word, in order.
// i_cfg writes dsp_present (index 0) and bbit_enable (index 1) from data bit 0;
// it is always ready and should only be written while the unit is empty.
// Pipeline: a word accepted on i_in is registered in turn by decode and
// condition, by target add and select, and by the output register, which
// drives o_out.valid.
// Throughput: one word per cycle while o_out is not stalled; the 64-bit target
// add and the rs/rt equality compare each fill one stage.
// Reset clears all stage valid bits and both config registers to 0.
// When the receiver holds o_out.ready low the output word is held, earlier
// stages keep filling, and i_in.ready drops once all three stages are full.
`timescale 1ns / 1ps
`default_nettype none
module mips_branch_next_pc #(
    parameter int REG_WIDTH = mbnp_pkg::REG_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mbnp_in_if.sink     i_in,
    mbnp_out_if.source  o_out,
    mbnp_cfg_if.sink    i_cfg
);
    import mbnp_pkg::*;

    t_cfg  r_cfg;

    logic  dec_vld;
    logic  dec_ready;
    t_dec  dec;
    logic  tgt_vld;
    logic  tgt_ready;
    t_res  tgt;

    logic  r_out_vld;
    t_res  r_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DSP_PRESENT: r_cfg.dsp_present <= i_cfg.data[0];
                CFG_BBIT_ENABLE: r_cfg.bbit_enable <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    mbnp_decode #(
        .REG_WIDTH (REG_WIDTH)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_in.valid),
        .o_ready    (i_in.ready),
        .i_instr    (i_in.instr),
        .i_pc       (i_in.pc),
        .i_rs_value (i_in.rs_value),
        .i_rt_value (i_in.rt_value),
        .i_fp_csr   (i_in.fp_csr),
        .i_dsp_pos  (i_in.dsp_pos),
        .i_cfg      (r_cfg),
        .o_vld      (dec_vld),
        .i_ready    (dec_ready),
        .o_dec      (dec)
    );

    mbnp_target #(
        .REG_WIDTH (REG_WIDTH)
    ) u_target (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dec_vld),
        .o_ready (dec_ready),
        .i_dec   (dec),
        .o_vld   (tgt_vld),
        .i_ready (tgt_ready),
        .o_res   (tgt)
    );

    assign tgt_ready = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (tgt_ready) begin
            r_out_vld <= tgt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tgt_ready && tgt_vld) begin
            r_out <= tgt;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.next_pc      = r_out.next_pc;
    assign o_out.link_write   = r_out.link_write;
    assign o_out.link_reg     = r_out.link_reg;
    assign o_out.link_value   = r_out.link_value;
    assign o_out.likely_taken = r_out.likely_taken;
    assign o_out.status       = r_out.status;

    a_misalign_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.status == ST_MISALIGN)
        |-> !r_out.link_write && (r_out.next_pc[1:0] != 2'b00))
        else $error("misaligned word produced a link or aligned next pc");

    a_likely_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.likely_taken |-> r_out.status == ST_OK)
        else $error("likely-taken flag set on an error word");

    a_nolink_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.link_write
        |-> (r_out.link_reg == 5'd0) && (r_out.link_value == 64'd0))
        else $error("link fields nonzero without link write");

    a_nodsp_nolink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.status == ST_NO_DSP)
        |-> !r_out.link_write && !r_out.likely_taken)
        else $error("DSP error word carries branch effects");

endmodule
`default_nettype wire

### sv/mbnp_decode.sv
// Stage 1: instruction decode, branch condition evaluation, link address.
`timescale 1ns / 1ps
`default_nettype none
module mbnp_decode #(
    parameter int REG_WIDTH = mbnp_pkg::REG_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    output logic                o_ready,
    input  wire logic [31:0]    i_instr,
    input  wire logic [63:0]    i_pc,
    input  wire logic [63:0]    i_rs_value,
    input  wire logic [63:0]    i_rt_value,
    input  wire logic [31:0]    i_fp_csr,
    input  wire logic [5:0]     i_dsp_pos,
    input  wire mbnp_pkg::t_cfg i_cfg,
    output logic                o_vld,
    input  wire logic           i_ready,
    output mbnp_pkg::t_dec      o_dec
);
    import mbnp_pkg::*;

    localparam logic [63:0] W_MASK = {64{1'b1}} >> (64 - REG_WIDTH);

    logic [5:0]  op;
    logic [4:0]  rsf;
    logic [4:0]  rtf;
    logic [4:0]  rdf;
    logic [5:0]  fn;
    logic [63:0] rs_w;
    logic [63:0] rs_x;
    logic        rneg;
    logic        rzero;
    logic        req;
    logic [2:0]  fcc;
    logic [4:0]  fbit;
    logic        fset;
    logic [5:0]  bsel;
    logic        bset;
    logic        bbit_hi;
    logic        bbit_one;

    logic  r_vld;
    t_dec  r_dec;
    t_dec  n_dec;

    assign op    = i_instr[31:26];
    assign rsf   = i_instr[25:21];
    assign rtf   = i_instr[20:16];
    assign rdf   = i_instr[15:11];
    assign fn    = i_instr[5:0];

    assign rneg  = i_rs_value[REG_WIDTH-1];
    assign rs_w  = i_rs_value & W_MASK;
    assign rs_x  = rs_w | ({64{rneg}} & ~W_MASK);
    assign rzero = (rs_w == 64'd0);
    assign req   = (((i_rs_value ^ i_rt_value) & W_MASK) == 64'd0);

    assign fcc   = rtf[4:2];
    assign fbit  = (fcc == 3'd0) ? FCC0_BIT : (FCC_BASE + {2'b00, fcc});
    assign fset  = i_fp_csr[fbit];

    assign bbit_hi  = (op == OP_BBIT032) || (op == OP_BBIT132);
    assign bbit_one = (op == OP_BBIT1) || (op == OP_BBIT132);
    assign bsel     = {bbit_hi, rtf};
    assign bset     = rs_x[bsel];

    always_comb begin
        n_dec        = '0;
        n_dec.pc     = i_pc;
        n_dec.pc4    = i_pc + 64'd4;
        n_dec.pc8    = i_pc + 64'd8;
        n_dec.off    = {{46{i_instr[15]}}, i_instr[15:0], 2'b00};
        n_dec.rs_w   = rs_w;
        n_dec.jidx   = i_instr[25:0];
        n_dec.sel    = SEL_PC;
        n_dec.status = ST_OK;
        if (i_pc[1:0] != 2'b00) begin
            n_dec.status = ST_MISALIGN;
        end else begin
            case (op)
                OP_SPECIAL: begin
                    if (fn == FN_JALR) begin
                        n_dec.link = 1'b1;
                        n_dec.lreg = rdf;
                    end
                    if (fn == FN_JR || fn == FN_JALR) begin
                        n_dec.sel = SEL_REG;
                    end
                end
                OP_REGIMM: begin
                    case (rtf)
                        RT_BLTZ, RT_BLTZL, RT_BLTZAL, RT_BLTZALL: begin
                            n_dec.sel   = SEL_BRANCH;
                            n_dec.taken = rneg;
                        end
                        RT_BGEZ, RT_BGEZL, RT_BGEZAL, RT_BGEZALL: begin
                            n_dec.sel   = SEL_BRANCH;
                            n_dec.taken = !rneg;
                        end
                        RT_BPOSGE32: begin
                            if (!i_cfg.dsp_present) begin
                                n_dec.status = ST_NO_DSP;
                            end else begin
                                n_dec.sel   = SEL_BRANCH;
                                n_dec.taken = i_dsp_pos[5];
                            end
                        end
                        default: ;
                    endcase
                    n_dec.likely = (rtf == RT_BLTZL) || (rtf == RT_BGEZL)
                                || (rtf == RT_BLTZALL) || (rtf == RT_BGEZALL);
                    if (rtf == RT_BLTZAL || rtf == RT_BGEZAL
                        || rtf == RT_BLTZALL || rtf == RT_BGEZALL) begin
                        n_dec.link = 1'b1;
                        n_dec.lreg = LINK_RA;
                    end
                end
                OP_JAL: begin
                    n_dec.link = 1'b1;
                    n_dec.lreg = LINK_RA;
                    n_dec.sel  = SEL_JUMP;
                end
                OP_J: begin
                    n_dec.sel = SEL_JUMP;
                end
                OP_BEQ, OP_BEQL: begin
                    n_dec.sel    = SEL_BRANCH;
                    n_dec.taken  = req;
                    n_dec.likely = (op == OP_BEQL);
                end
                OP_BNE, OP_BNEL: begin
                    n_dec.sel    = SEL_BRANCH;
                    n_dec.taken  = !req;
                    n_dec.likely = (op == OP_BNEL);
                end
                OP_BLEZ, OP_BLEZL: begin
                    n_dec.sel    = SEL_BRANCH;
                    n_dec.taken  = rneg || rzero;
                    n_dec.likely = (op == OP_BLEZL);
                end
                OP_BGTZ, OP_BGTZL: begin
                    n_dec.sel    = SEL_BRANCH;
                    n_dec.taken  = !rneg && !rzero;
                    n_dec.likely = (op == OP_BGTZL);
                end
                OP_COP1: begin
                    if (rsf == COP1_BC) begin
                        n_dec.sel    = SEL_BRANCH;
                        n_dec.taken  = rtf[0] ? fset : !fset;
                        n_dec.likely = rtf[1];
                    end
                end
                OP_BBIT0, OP_BBIT032, OP_BBIT1, OP_BBIT132: begin
                    if (i_cfg.bbit_enable) begin
                        n_dec.sel   = SEL_BRANCH;
                        n_dec.taken = bbit_one ? bset : !bset;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_dec <= n_dec;
        end
    end

    assign o_vld = r_vld;
    assign o_dec = r_dec;

endmodule
`default_nettype wire

### sv/mbnp_target.sv
// Stage 2: branch target add and next-PC / link selection.
`timescale 1ns / 1ps
`default_nettype none
module mbnp_target #(
    parameter int REG_WIDTH = mbnp_pkg::REG_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    output logic                o_ready,
    input  wire mbnp_pkg::t_dec i_dec,
    output logic                o_vld,
    input  wire logic           i_ready,
    output mbnp_pkg::t_res      o_res
);
    import mbnp_pkg::*;

    localparam logic [63:0] W_MASK = {64{1'b1}} >> (64 - REG_WIDTH);

    logic [63:0] br_tgt;
    logic [63:0] jmp_tgt;

    logic  r_vld;
    t_res  r_res;
    t_res  n_res;

    assign br_tgt  = i_dec.pc4 + i_dec.off;
    assign jmp_tgt = {i_dec.pc4[63:28], i_dec.jidx, 2'b00};

    always_comb begin
        n_res = '0;
        case (i_dec.sel)
            SEL_PC:     n_res.next_pc = i_dec.pc;
            SEL_REG:    n_res.next_pc = i_dec.rs_w;
            SEL_JUMP:   n_res.next_pc = jmp_tgt & W_MASK;
            SEL_BRANCH: n_res.next_pc = (i_dec.taken ? br_tgt : i_dec.pc8) & W_MASK;
            default:    n_res.next_pc = i_dec.pc;
        endcase
        n_res.link_write   = i_dec.link;
        n_res.link_reg     = i_dec.link ? i_dec.lreg : 5'd0;
        n_res.link_value   = i_dec.link ? (i_dec.pc8 & W_MASK) : 64'd0;
        n_res.likely_taken = (i_dec.sel == SEL_BRANCH) && i_dec.taken && i_dec.likely;
        n_res.status       = i_dec.status;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule
`default_nettype wire
